FILE: src/rtmia_pkg.sv
// Shared constants and types for the RTM imaging accumulator.
`timescale 1ns / 1ps

package rtmia_pkg;

  // Default image store depth.
  localparam int IMAGE_DEPTH_DEF = 65536;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 16;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int SCALE_W  = 16;
  localparam int SCALED_W = 48;
  localparam int INC_W    = SCALED_W - SCALE_W;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 48;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKSCATTER  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 2'd3;

  // Item kinds.
  localparam logic KIND_ACCUM = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Imaging modes.
  localparam logic MODE_CONVENTIONAL = 1'b0;
  localparam logic MODE_POYNTING     = 1'b1;

  // Poynting gate orientations.
  localparam logic [2:0] ORIENT_BOTH       = 3'd0;
  localparam logic [2:0] ORIENT_VERTICAL   = 3'd1;
  localparam logic [2:0] ORIENT_HORIZONTAL = 3'd2;

  // Time step after reset.
  localparam logic [SCALE_W-1:0] TIME_STEP_RESET = 16'hFFFF;

  // Rounding offset for the Q2.46 to Q17.30 conversion.
  localparam logic signed [SCALED_W-1:0] ROUND_HALF = 48'sd32768;

  // Saturation limits.
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

FILE: src/rtm_imaging_accumulator_core.sv
// Top level of the RTM zero-lag cross-correlation imaging accumulator.
`timescale 1ns / 1ps

// The block takes one item per clock cycle when the output side does not stall
// and no clearing pass runs, and returns one result per item.
// The pixel read-modify-write is spread over four register stages with the
// image store read at the first and written at the last; results of earlier
// items to the same pixel are forwarded into later stages, so repeated
// accesses to one pixel also run at one item per cycle. After reset the
// image store is cleared one entry per cycle, and during this pass no input
// item is accepted (configuration writes are taken).
// Configuration must be written only while the block is idle.
module rtm_imaging_accumulator_core #(
  parameter int IMAGE_DEPTH = rtmia_pkg::IMAGE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [rtmia_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtmia_pkg::CFG_W-1:0]         cfg_wdata,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: pixel_index, src_pressure, src_vel_x, src_vel_z,
  // rcv_pressure, rcv_vx_here, rcv_vx_next, rcv_vz_here, rcv_vz_next.
  input  logic [rtmia_pkg::IN_DATA_W-1:0]     in_tdata,
  // Fields from bit 0: kind.
  input  logic                                in_tuser,
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: pixel_value.
  output logic [rtmia_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Fields from bit 0: imaged.
  output logic                                out_tuser
);

  localparam int ADDR_W = (IMAGE_DEPTH > 1) ? $clog2(IMAGE_DEPTH) : 1;
  // The index width must also hold IMAGE_DEPTH itself for the range check.
  localparam int XW     = (ADDR_W >= rtmia_pkg::INDEX_W) ? ADDR_W + 1 : rtmia_pkg::INDEX_W;
  localparam int SW     = rtmia_pkg::SAMPLE_W;
  localparam int AW     = rtmia_pkg::ACC_W;

  // Configuration registers.
  logic                            imaging_mode_r;
  logic [2:0]                      orientation_r;
  logic                            backscatter_r;
  logic [rtmia_pkg::SCALE_W-1:0]   time_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imaging_mode_r <= rtmia_pkg::MODE_CONVENTIONAL;
      orientation_r  <= rtmia_pkg::ORIENT_BOTH;
      backscatter_r  <= 1'b0;
      time_step_r    <= rtmia_pkg::TIME_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rtmia_pkg::REG_IMAGING_MODE: imaging_mode_r <= cfg_wdata[0];
        rtmia_pkg::REG_ORIENTATION:  orientation_r  <= cfg_wdata[2:0];
        rtmia_pkg::REG_BACKSCATTER:  backscatter_r  <= cfg_wdata[0];
        rtmia_pkg::REG_TIME_STEP:    time_step_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clearing pass over the image store after reset.
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == ADDR_W'(IMAGE_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Pipeline control: every stage moves when the output register can take data.
  logic out_valid_r;
  logic adv;
  logic in_xfer;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv && !clr_active_r;
  assign in_xfer   = in_tvalid && in_tready;

  // Stage 1: captured input item.
  logic          v1_r;
  logic          kind1_r;
  logic [XW-1:0] idx1_r;
  logic [SW-1:0] sp1_r, svx1_r, svz1_r, rp1_r, rvxh1_r, rvxn1_r, rvzh1_r, rvzn1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= in_tuser;
      idx1_r  <= XW'(in_tdata[15:0]);
      sp1_r   <= in_tdata[31:16];
      svx1_r  <= in_tdata[47:32];
      svz1_r  <= in_tdata[63:48];
      rp1_r   <= in_tdata[79:64];
      rvxh1_r <= in_tdata[95:80];
      rvxn1_r <= in_tdata[111:96];
      rvzh1_r <= in_tdata[127:112];
      rvzn1_r <= in_tdata[143:128];
    end
  end

  // Stage 1 logic: range check, Poynting gate and the pressure product.
  logic              in_range1;
  logic [ADDR_W-1:0] addr1;
  logic signed [SW:0] rvx1, rvz1;
  logic              src_x_nz, src_z_nz, rcv_x_nz, rcv_z_nz;
  logic              src_x_neg, src_z_neg, rcv_x_neg, rcv_z_neg;
  logic              same_x, opp_x, same_z, opp_z;
  logic              pass1;
  logic              wr1;
  logic signed [rtmia_pkg::PROD_W-1:0] prod1;

  assign in_range1 = idx1_r < XW'(IMAGE_DEPTH);
  assign addr1     = idx1_r[ADDR_W-1:0];
  assign rvx1      = $signed({rvxh1_r[SW-1], rvxh1_r}) + $signed({rvxn1_r[SW-1], rvxn1_r});
  assign rvz1      = $signed({rvzh1_r[SW-1], rvzh1_r}) + $signed({rvzn1_r[SW-1], rvzn1_r});

  // Flux signs are products of factor signs; a zero factor gives no direction.
  assign src_x_nz  = (sp1_r != '0) && (svx1_r != '0);
  assign src_z_nz  = (sp1_r != '0) && (svz1_r != '0);
  assign rcv_x_nz  = (rp1_r != '0) && (rvx1 != '0);
  assign rcv_z_nz  = (rp1_r != '0) && (rvz1 != '0);
  assign src_x_neg = sp1_r[SW-1] ^ svx1_r[SW-1];
  assign src_z_neg = sp1_r[SW-1] ^ svz1_r[SW-1];
  assign rcv_x_neg = rp1_r[SW-1] ^ rvx1[SW];
  assign rcv_z_neg = rp1_r[SW-1] ^ rvz1[SW];
  assign same_x    = src_x_nz && rcv_x_nz && (src_x_neg == rcv_x_neg);
  assign opp_x     = src_x_nz && rcv_x_nz && (src_x_neg != rcv_x_neg);
  assign same_z    = src_z_nz && rcv_z_nz && (src_z_neg == rcv_z_neg);
  assign opp_z     = src_z_nz && rcv_z_nz && (src_z_neg != rcv_z_neg);

  always_comb begin
    if (imaging_mode_r == rtmia_pkg::MODE_CONVENTIONAL) begin
      pass1 = 1'b1;
    end else begin
      case (orientation_r)
        rtmia_pkg::ORIENT_BOTH:       pass1 = backscatter_r ? (same_x && same_z)
                                                            : (opp_x || opp_z);
        rtmia_pkg::ORIENT_VERTICAL:   pass1 = same_z;
        rtmia_pkg::ORIENT_HORIZONTAL: pass1 = opp_x;
        default:                      pass1 = 1'b0;
      endcase
    end
  end

  assign wr1   = in_range1 && (kind1_r == rtmia_pkg::KIND_ACCUM) && pass1;
  assign prod1 = $signed(rp1_r) * $signed(sp1_r);

  // Commit of the last stage, used for forwarding into earlier stages.
  logic              commit;
  logic [ADDR_W-1:0] addr4_r;
  logic [AW-1:0]     sum4;

  // Image store with registered read; the clearing pass owns the write port.
  logic [AW-1:0] mem [IMAGE_DEPTH];
  logic [AW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (commit) begin
      mem[addr4_r] <= sum4;
    end
    if (adv) begin
      rdata_r <= mem[addr1];
    end
  end

  // Stage 2: pressure product, gate result and read data.
  logic              v2_r, wr2_r, in_range2_r, fwd2_r;
  logic [ADDR_W-1:0] addr2_r;
  logic [AW-1:0]     fwdv2_r;
  logic signed [rtmia_pkg::PROD_W-1:0] prod2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr2_r       <= wr1;
      in_range2_r <= in_range1;
      addr2_r     <= addr1;
      prod2_r     <= prod1;
      fwd2_r      <= commit && (addr4_r == addr1);
      fwdv2_r     <= sum4;
    end
  end

  // Stage 2 logic: scale by the time step and pick the current pixel.
  logic signed [rtmia_pkg::PROD_W+rtmia_pkg::SCALE_W:0] scaled2;
  logic [AW-1:0] pix2;

  assign scaled2 = prod2_r * $signed({1'b0, time_step_r});
  assign pix2    = (commit && (addr4_r == addr2_r)) ? sum4 :
                   (fwd2_r ? fwdv2_r : rdata_r);

  // Stage 3: scaled product in Q2.46.
  logic              v3_r, wr3_r, in_range3_r;
  logic [ADDR_W-1:0] addr3_r;
  logic [AW-1:0]     pix3_r;
  logic signed [rtmia_pkg::SCALED_W-1:0] scaled3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr3_r       <= wr2_r;
      in_range3_r <= in_range2_r;
      addr3_r     <= addr2_r;
      pix3_r      <= pix2;
      scaled3_r   <= scaled2[rtmia_pkg::SCALED_W-1:0];
    end
  end

  // Stage 3 logic: round to nearest, ties up, into Q17.30.
  logic signed [rtmia_pkg::SCALED_W-1:0] rounded3;
  logic [AW-1:0] pix3;

  assign rounded3 = scaled3_r + rtmia_pkg::ROUND_HALF;
  assign pix3     = (commit && (addr4_r == addr3_r)) ? sum4 : pix3_r;

  // Stage 4: increment and current pixel.
  logic                              v4_r, wr4_r, in_range4_r;
  logic [AW-1:0]                     pix4_r;
  logic signed [rtmia_pkg::INC_W-1:0] inc4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr4_r       <= wr3_r;
      in_range4_r <= in_range3_r;
      addr4_r     <= addr3_r;
      pix4_r      <= pix3;
      inc4_r      <= rounded3[rtmia_pkg::SCALED_W-1:rtmia_pkg::SCALE_W];
    end
  end

  // Stage 4 logic: saturating add into the pixel.
  logic signed [AW:0] wide4;

  assign wide4 = $signed({pix4_r[AW-1], pix4_r}) +
                 $signed({{(AW+1-rtmia_pkg::INC_W){inc4_r[rtmia_pkg::INC_W-1]}}, inc4_r});

  always_comb begin
    if (wide4[AW] != wide4[AW-1]) begin
      sum4 = wide4[AW] ? rtmia_pkg::ACC_MIN : rtmia_pkg::ACC_MAX;
    end else begin
      sum4 = wide4[AW-1:0];
    end
  end

  assign commit = adv && v4_r && wr4_r;

  // Output register.
  logic [AW-1:0] out_pix_r;
  logic          out_imaged_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_imaged_r <= wr4_r;
      if (!in_range4_r) begin
        out_pix_r <= '0;
      end else if (wr4_r) begin
        out_pix_r <= sum4;
      end else begin
        out_pix_r <= pix4_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_imaged_r;

endmodule
